// ===== rtl/otp_md5_fold_chain_assert.svh =====
// ----------------------------------------------------------------------------
// otp_md5_fold_chain assertion macros
// Concurrent checks for the folded hash chain. They compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef OTP_MD5_FOLD_CHAIN_ASSERT_SVH
`define OTP_MD5_FOLD_CHAIN_ASSERT_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle as ante
`define MF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that cons holds in the cycle after ante
`define MF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MF_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MF_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/md5fold_pkg.sv =====
// ----------------------------------------------------------------------------
// md5fold_pkg
// Types, initial chaining words and step tables of the MD5 compression
// function as used by the folded hash chain.
// ----------------------------------------------------------------------------
package md5fold_pkg;

  // Working words of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_state_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam md5_state_t IV_STATE = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};

  // Padding word after the 8-byte message, and its length in bits
  localparam logic [31:0] PAD_WORD = 32'h00000080;
  localparam logic [31:0] LEN_WORD = 32'h00000040;

  localparam logic [5:0] LAST_STEP = 6'd63;

  // Additive constant of each step
  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotation of each step, by round and position within the group of four
  function automatic logic [4:0] step_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd7;
    endcase
    return s;
  endfunction

  // Message word index taken by each step
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] g;
    j = i[3:0];
    case (i[5:4])
      2'd0:    g = j;
      2'd1:    g = 4'(j * 4'd5 + 4'd1);
      2'd2:    g = 4'(j * 4'd3 + 4'd5);
      default: g = 4'(j * 4'd7);
    endcase
    return g;
  endfunction

  // Message word of the single padded block built from the 64-bit value
  function automatic logic [31:0] msg_word(input logic [3:0] g, input logic [63:0] v);
    logic [31:0] w;
    case (g)
      4'd0:    w = v[31:0];
      4'd1:    w = v[63:32];
      4'd2:    w = PAD_WORD;
      4'd14:   w = LEN_WORD;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/otp_md5_fold_chain.sv =====
// ----------------------------------------------------------------------------
// otp_md5_fold_chain
// Folded MD5 hash chain: hashes a 64-bit value as one padded block a given
// number of times, folding each digest to 64 bits (high b^d, low a^c).
// ----------------------------------------------------------------------------
//
//  Channel   Signals                       Direction  Handshake
//  request   start, seed, iterations       in         taken when start & !busy
//  result    done, folded_value            out        done strobe, one cycle
//
// Each iteration runs 64 MD5 steps through the single step unit, one step
// a cycle, then adds the chaining words and folds the digest.
// A request with count N raises done after N iterations; a count of zero
// gives the seed back with done in the next cycle.
// busy falls in the cycle in which done is shown, so a new request may be
// taken then. Reset is synchronous and needs no clearing pass; the receiver
// cannot stall.
//
`include "otp_md5_fold_chain_assert.svh"

module otp_md5_fold_chain #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] seed,
  input  logic [15:0] iterations,
  output logic        done,
  output logic [63:0] folded_value
);
  import md5fold_pkg::*;

  // Only the low COUNT_BITS (at most 16) of the 16-bit count are used
  localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD
  } state_t;

  state_t           state;
  logic [5:0]       step;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] req_cnt;
  logic [63:0]      value;
  md5_state_t       hs;
  md5_state_t       hs_next;
  logic [31:0]      dig_a;
  logic [31:0]      dig_b;
  logic [31:0]      dig_c;
  logic [31:0]      dig_d;
  logic [63:0]      fold;

  assign req_cnt = iterations[CNT_W-1:0];
  assign busy    = (state != S_IDLE);

  // Shared step unit
  md5fold_step u_step (
    .step  (step),
    .value (value),
    .cur   (hs),
    .nxt   (hs_next)
  );

  // Add the chaining words and fold the digest
  assign dig_a = hs.a + IV_A;
  assign dig_b = hs.b + IV_B;
  assign dig_c = hs.c + IV_C;
  assign dig_d = hs.d + IV_D;
  assign fold  = {dig_b ^ dig_d, dig_a ^ dig_c};

  // Sequencer: hold state, step counter, iteration count and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            value <= seed;
            cnt   <= req_cnt;
            step  <= '0;
            hs    <= IV_STATE;
            if (req_cnt == '0) begin
              folded_value <= seed;
              done         <= 1'b1;
            end else begin
              state <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          hs   <= hs_next;
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          value <= fold;
          hs    <= IV_STATE;
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            folded_value <= fold;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_ROUND;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `MF_ASSERT_SAME(a_done_not_busy, clk, rst, done, !busy, "result shown while busy")
  `MF_ASSERT_NEXT(a_zero_passes_seed, clk, rst,
                  start && !busy && req_cnt == '0,
                  done && folded_value == $past(seed),
                  "zero count did not return seed")
  `MF_ASSERT_NEXT(a_count_starts, clk, rst,
                  start && !busy && req_cnt != '0,
                  busy && !done && step == 6'd0,
                  "request with count did not start")
  `MF_ASSERT_NEXT(a_last_step_folds, clk, rst,
                  state == S_ROUND && step == LAST_STEP,
                  state == S_FOLD && step == 6'd0,
                  "fold did not follow last step")
  `MF_ASSERT_SAME(a_done_source, clk, rst, done,
                  $past(state == S_FOLD) || $past(start && !busy),
                  "result without cause")

endmodule

// ===== rtl/md5fold_step.sv =====
// ----------------------------------------------------------------------------
// md5fold_step
// One MD5 step: round function, four-way add, rotation and word shuffle.
// Purely combinational; the sequencer registers the result.
// ----------------------------------------------------------------------------
module md5fold_step (
  input  logic [5:0]               step,
  input  logic [63:0]              value,
  input  md5fold_pkg::md5_state_t  cur,
  output md5fold_pkg::md5_state_t  nxt
);
  import md5fold_pkg::*;

  logic [31:0] f;
  logic [31:0] mword;
  logic [31:0] t;
  logic [63:0] rot_wide;

  // Pick the round function
  always_comb begin
    case (step[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
  end

  // Sum the step terms and rotate
  assign mword    = msg_word(msg_index(step), value);
  assign t        = cur.a + f + mword + step_const(step);
  assign rot_wide = {t, t} << step_rot(step);

  // Shuffle the working words
  always_comb begin
    nxt.a = cur.d;
    nxt.d = cur.c;
    nxt.c = cur.b;
    nxt.b = cur.b + rot_wide[63:32];
  end

endmodule
